// ===== hw/rtl/mcr_pkg.sv =====
// Shared types, constants and helpers for the midpoint circle rasterizer.
// No dependencies; compiled first.
package mcr_pkg;

  localparam int COORD_WIDTH_DEF  = 12;
  localparam int RADIUS_WIDTH_DEF = 11;
  localparam int PIX_WIDTH        = 14;
  localparam int JOBQ_DEPTH       = 2;
  localparam int PIX_PER_START    = 4;
  localparam int PIX_PER_STEP     = 8;
  localparam int IDX_W            = $clog2(PIX_PER_STEP);

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef struct packed {
    logic swap;
    logic neg_row;
    logic neg_col;
  } mirror_t;

  // Octant selection for pixel idx of a step or start item.
  function automatic mirror_t mirror_sel(logic is_start, logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] k;
    mirror_t m;
    k = idx;
    if (is_start) begin
      case (idx)
        IDX_W'(0): k = IDX_W'(0);
        IDX_W'(1): k = IDX_W'(2);
        IDX_W'(2): k = IDX_W'(4);
        default:   k = IDX_W'(5);
      endcase
    end
    m.swap    = k[2];
    m.neg_row = k[1];
    m.neg_col = k[0];
    return m;
  endfunction

endpackage

// ===== hw/rtl/mcr_if.sv =====
// Valid/ready channel interfaces of the circle rasterizer.
// Depends on mcr_pkg.
interface mcr_in_if #(
  parameter int COORD_WIDTH  = mcr_pkg::COORD_WIDTH_DEF,
  parameter int RADIUS_WIDTH = mcr_pkg::RADIUS_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [COORD_WIDTH-1:0]  center_x;
  logic [COORD_WIDTH-1:0]  center_y;
  logic [RADIUS_WIDTH-1:0] radius;

  modport source (output valid, op, center_x, center_y, radius, input ready);
  modport sink   (input valid, op, center_x, center_y, radius, output ready);
endinterface

interface mcr_out_if;
  import mcr_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [PIX_WIDTH-1:0] pixel_x;
  logic signed [PIX_WIDTH-1:0] pixel_y;
  logic                        last_of_item;
  logic                        circle_done;

  modport source (output valid, pixel_x, pixel_y, last_of_item, circle_done, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_of_item, circle_done, output ready);
endinterface

// ===== hw/rtl/midpoint_circle_rasterizer.sv =====
// Midpoint circle rasterizer, top level: front end, job queue, back end.
// The first pixel of an item passes the job queue, the job register and the output register.
// One pixel per cycle while out_ch.ready allows; a start item emits 4 pixels, a step 8,
// through the single-pixel output port; a step while idle emits nothing.
// Reset (rst_n, synchronous): no circle running, queue and output empty.
module midpoint_circle_rasterizer #(
  parameter int COORD_WIDTH  = mcr_pkg::COORD_WIDTH_DEF,
  parameter int RADIUS_WIDTH = mcr_pkg::RADIUS_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  mcr_in_if.sink    in_ch,
  mcr_out_if.source out_ch
);
  import mcr_pkg::*;

  localparam int JOB_W = 2 * COORD_WIDTH + 2 * RADIUS_WIDTH + 2;

  logic             q_push, q_full, q_valid, q_pop;
  logic [JOB_W-1:0] q_din, q_dout;

  mcr_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .RADIUS_WIDTH(RADIUS_WIDTH),
    .JOB_W       (JOB_W)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_full(q_full),
    .q_push(q_push),
    .q_job (q_din)
  );

  mcr_job_queue #(
    .WIDTH(JOB_W),
    .DEPTH(JOBQ_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  (q_din),
    .full (q_full),
    .valid(q_valid),
    .pop  (q_pop),
    .dout (q_dout)
  );

  mcr_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .RADIUS_WIDTH(RADIUS_WIDTH),
    .JOB_W       (JOB_W)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_valid(q_valid),
    .q_job  (q_dout),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

// ===== hw/rtl/mcr_front.sv =====
// Front end: accepts start/step transfers, runs the midpoint update,
// pushes pixel jobs into the queue. Depends on mcr_pkg, mcr_if.
module mcr_front #(
  parameter int COORD_WIDTH  = mcr_pkg::COORD_WIDTH_DEF,
  parameter int RADIUS_WIDTH = mcr_pkg::RADIUS_WIDTH_DEF,
  parameter int JOB_W        = 2 * COORD_WIDTH + 2 * RADIUS_WIDTH + 2
) (
  input  logic             clk,
  input  logic             rst_n,
  mcr_in_if.sink           in_ch,
  input  logic             q_full,
  output logic             q_push,
  output logic [JOB_W-1:0] q_job
);
  import mcr_pkg::*;

  localparam int RW = RADIUS_WIDTH;
  localparam int TW = RADIUS_WIDTH + 2;
  localparam int DW = RADIUS_WIDTH + 3;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] cx;
    logic [COORD_WIDTH-1:0] cy;
    logic [RW-1:0]          ox;
    logic [RW-1:0]          oy;
    logic                   is_start;
    logic                   done;
  } job_t;

  logic [COORD_WIDTH-1:0] centre_col_r, centre_row_r;
  logic [RW-1:0]          offset_x_r, offset_y_r, offset_x_nxt, offset_y_nxt;
  logic signed [DW-1:0]   decision_r, decision_nxt, dec_mid;
  logic signed [TW-1:0]   step_x_r, step_y_r, step_x_nxt, step_y_nxt;
  logic                   running_r, running_nxt;
  logic                   accept, is_step, dec_ge, step_done;
  job_t                   job;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign is_step     = (in_ch.op == OP_STEP);

  // one midpoint iteration
  assign dec_ge       = !decision_r[DW-1];
  assign offset_y_nxt = dec_ge ? offset_y_r - RW'(1) : offset_y_r;
  assign step_y_nxt   = dec_ge ? step_y_r + TW'(2) : step_y_r;
  assign dec_mid      = dec_ge ? decision_r + DW'(step_y_nxt) : decision_r;
  assign offset_x_nxt = offset_x_r + RW'(1);
  assign step_x_nxt   = step_x_r + TW'(2);
  assign decision_nxt = dec_mid + DW'(step_x_nxt) + DW'(1);
  assign step_done    = !(offset_x_nxt < offset_y_nxt);
  assign running_nxt  = (in_ch.radius != '0);

  always_comb begin
    job    = '0;
    q_push = 1'b0;
    if (accept) begin
      if (!is_step) begin
        q_push       = 1'b1;
        job.cx       = in_ch.center_x;
        job.cy       = in_ch.center_y;
        job.ox       = '0;
        job.oy       = in_ch.radius;
        job.is_start = 1'b1;
        job.done     = !running_nxt;
      end else if (running_r) begin
        q_push       = 1'b1;
        job.cx       = centre_col_r;
        job.cy       = centre_row_r;
        job.ox       = offset_x_nxt;
        job.oy       = offset_y_nxt;
        job.is_start = 1'b0;
        job.done     = step_done;
      end
    end
  end

  assign q_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_col_r <= '0;
      centre_row_r <= '0;
      offset_x_r   <= '0;
      offset_y_r   <= '0;
      decision_r   <= '0;
      step_x_r     <= '0;
      step_y_r     <= '0;
      running_r    <= 1'b0;
    end else if (accept) begin
      if (!is_step) begin
        centre_col_r <= in_ch.center_x;
        centre_row_r <= in_ch.center_y;
        offset_x_r   <= '0;
        offset_y_r   <= in_ch.radius;
        decision_r   <= DW'(1) - DW'(in_ch.radius);
        step_x_r     <= '0;
        step_y_r     <= TW'(0) - TW'({in_ch.radius, 1'b0});
        running_r    <= running_nxt;
      end else if (running_r) begin
        offset_x_r <= offset_x_nxt;
        offset_y_r <= offset_y_nxt;
        decision_r <= decision_nxt;
        step_x_r   <= step_x_nxt;
        step_y_r   <= step_y_nxt;
        running_r  <= !step_done;
      end
    end
  end

endmodule

// ===== hw/rtl/mcr_job_queue.sv =====
// Small register FIFO of pixel jobs between front and back end.
// Depends on mcr_pkg.
module mcr_job_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mcr_pkg::JOBQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  output logic             valid,
  input  logic             pop,
  output logic [WIDTH-1:0] dout
);
  import mcr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign valid   = (count_r != '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("job pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> valid)
    else $error("job popped from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with empty count");

endmodule

// ===== hw/rtl/mcr_back.sv =====
// Back end: expands each job into its mirrored pixels, one per cycle while out_ch.ready allows,
// through a registered output stage. Depends on mcr_pkg, mcr_if.
module mcr_back #(
  parameter int COORD_WIDTH  = mcr_pkg::COORD_WIDTH_DEF,
  parameter int RADIUS_WIDTH = mcr_pkg::RADIUS_WIDTH_DEF,
  parameter int JOB_W        = 2 * COORD_WIDTH + 2 * RADIUS_WIDTH + 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  logic [JOB_W-1:0] q_job,
  output logic             q_pop,
  mcr_out_if.source        out_ch
);
  import mcr_pkg::*;

  localparam int RW = RADIUS_WIDTH;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] cx;
    logic [COORD_WIDTH-1:0] cy;
    logic [RW-1:0]          ox;
    logic [RW-1:0]          oy;
    logic                   is_start;
    logic                   done;
  } job_t;

  job_t                        job_r;
  logic                        busy_r;
  logic [IDX_W-1:0]            idx_r;
  logic                        out_valid_r;
  logic signed [PIX_WIDTH-1:0] pixel_x_r, pixel_y_r;
  logic                        last_r, done_r;

  logic                        adv, last_pix;
  mirror_t                     m;
  logic [PIX_WIDTH-1:0]        cx_w, cy_w, a_w, b_w, px, py;

  assign adv      = busy_r && (!out_valid_r || out_ch.ready);
  assign last_pix = job_r.is_start ? (idx_r == IDX_W'(PIX_PER_START - 1))
                                   : (idx_r == IDX_W'(PIX_PER_STEP - 1));
  assign q_pop    = q_valid && (!busy_r || (adv && last_pix));

  assign m    = mirror_sel(job_r.is_start, idx_r);
  assign cx_w = PIX_WIDTH'(job_r.cx);
  assign cy_w = PIX_WIDTH'(job_r.cy);
  assign a_w  = m.swap ? PIX_WIDTH'(job_r.oy) : PIX_WIDTH'(job_r.ox);
  assign b_w  = m.swap ? PIX_WIDTH'(job_r.ox) : PIX_WIDTH'(job_r.oy);
  assign px   = m.neg_col ? cx_w - a_w : cx_w + a_w;
  assign py   = m.neg_row ? cy_w - b_w : cy_w + b_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (adv) begin
        if (last_pix) begin
          busy_r <= 1'b0;
        end
        idx_r <= idx_r + IDX_W'(1);
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= job_t'(q_job);
    end
    if (adv) begin
      pixel_x_r <= $signed(px);
      pixel_y_r <= $signed(py);
      last_r    <= last_pix;
      done_r    <= last_pix && job_r.done;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_x      = pixel_x_r;
  assign out_ch.pixel_y      = pixel_y_r;
  assign out_ch.last_of_item = last_r;
  assign out_ch.circle_done  = done_r;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for midpoint_circle_rasterizer: a local circle predictor
// queues the pixels each transfer should cause, a monitor matches every output pixel.
// Depends on mcr_pkg, the mcr_in_if/mcr_out_if interfaces and the rasterizer RTL.
module tb_top;
  import mcr_pkg::*;

  localparam int CW          = COORD_WIDTH_DEF;
  localparam int RW          = RADIUS_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_PIX  = 50;

  typedef struct {
    logic signed [PIX_WIDTH-1:0] px;
    logic signed [PIX_WIDTH-1:0] py;
    logic                        last;
    logic                        done;
  } pixel_t;

  logic clk;
  logic rst_n;

  mcr_in_if  in_ch();
  mcr_out_if out_ch();

  midpoint_circle_rasterizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // predictor state
  logic [CW-1:0]        ctr_col;
  logic [CW-1:0]        ctr_row;
  logic [RW-1:0]        off_x;
  logic [RW-1:0]        off_y;
  logic signed [13:0]   decision;
  logic signed [12:0]   ddx;
  logic signed [12:0]   ddy;
  bit                   circle_active;

  pixel_t pending_pixels[$];
  int     errors;
  int     cycles;
  int     src_gap_max;
  int     snk_gap_max;
  int     hold_cycles;
  int     stall_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void push_pixel(int x, int y, bit last, bit done);
    pixel_t p;
    p.px   = PIX_WIDTH'(x);
    p.py   = PIX_WIDTH'(y);
    p.last = last;
    p.done = done;
    pending_pixels.push_back(p);
  endfunction

  // Advances the predicted circle by one transfer; returns pixels queued.
  function automatic int rasterize(op_t op, logic [CW-1:0] cx_in, logic [CW-1:0] cy_in,
                                   logic [RW-1:0] r);
    int  cx;
    int  cy;
    int  x;
    int  y;
    int  rad;
    bit  done;
    if (op == OP_START) begin
      rad           = r;
      ctr_col       = cx_in;
      ctr_row       = cy_in;
      off_x         = '0;
      off_y         = r;
      decision      = 14'(1 - rad);
      ddx           = '0;
      ddy           = 13'(-2 * rad);
      circle_active = (rad > 0);
      cx            = ctr_col;
      cy            = ctr_row;
      push_pixel(cx, cy + rad, 1'b0, 1'b0);
      push_pixel(cx, cy - rad, 1'b0, 1'b0);
      push_pixel(cx + rad, cy, 1'b0, 1'b0);
      push_pixel(cx - rad, cy, 1'b1, !circle_active);
      return PIX_PER_START;
    end
    if (!circle_active) return 0;
    if (decision >= 0) begin
      off_y    = off_y - 1'b1;
      ddy      = ddy + 13'sd2;
      decision = decision + ddy;
    end
    off_x    = off_x + 1'b1;
    ddx      = ddx + 13'sd2;
    decision = decision + ddx + 14'sd1;
    x    = off_x;
    y    = off_y;
    done = !(x < y);
    if (done) circle_active = 1'b0;
    cx = ctr_col;
    cy = ctr_row;
    push_pixel(cx + x, cy + y, 1'b0, 1'b0);
    push_pixel(cx - x, cy + y, 1'b0, 1'b0);
    push_pixel(cx + x, cy - y, 1'b0, 1'b0);
    push_pixel(cx - x, cy - y, 1'b0, 1'b0);
    push_pixel(cx + y, cy + x, 1'b0, 1'b0);
    push_pixel(cx - y, cy + x, 1'b0, 1'b0);
    push_pixel(cx + y, cy - x, 1'b0, 1'b0);
    push_pixel(cx - y, cy - x, 1'b1, done);
    return PIX_PER_STEP;
  endfunction

  // Valid stays high across back-to-back transfers; lowered only before a gap.
  task automatic send_item(op_t op, logic [CW-1:0] cx, logic [CW-1:0] cy, logic [RW-1:0] r,
                           output int n);
    int gap;
    gap = src_gap_max > 0 ? $urandom_range(0, src_gap_max) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.center_x <= cx;
    in_ch.center_y <= cy;
    in_ch.radius   <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n = rasterize(op, cx, cy, r);
  endtask

  task automatic send_step(output int n);
    send_item(OP_STEP, CW'($urandom), CW'($urandom), RW'($urandom), n);
  endtask

  // Start, then step until the circle is done or max_steps run out.
  task automatic run_circle(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [RW-1:0] r,
                            int max_steps, output int produced);
    int n;
    int steps;
    send_item(OP_START, cx, cy, r, n);
    produced = n;
    steps    = 0;
    while (circle_active && steps < max_steps) begin
      send_step(n);
      produced += n;
      steps++;
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed();
    int n;
    src_gap_max = 0;
    snk_gap_max = 0;
    send_step(n);                                   // step with no circle after reset
    run_circle(CW'(0), CW'(0), RW'(0), 4, n);       // zero radius
    send_step(n);                                   // step after done
    run_circle({CW{1'b1}}, {CW{1'b1}}, {RW{1'b1}}, 3, n);
    run_circle(CW'(0), CW'(0), {RW{1'b1}}, 2, n);   // negative coordinates
    run_circle(CW'(100), CW'(200), RW'(5), 10, n);
    send_step(n);
    run_circle(CW'(7), CW'(9), RW'(1), 10, n);      // diagonal right away
    run_circle(CW'(2730), CW'(1365), RW'(1365), 1, n);
    run_circle(CW'(300), CW'(40), RW'(3), 10, n);   // restarts the running circle
  endtask

  task automatic test_backpressure();
    int n;
    src_gap_max = 0;
    snk_gap_max = 0;
    hold_cycles = 200;
    run_circle(CW'(2048), CW'(2048), RW'(40), 14, n);
    snk_gap_max = 12;
    run_circle(CW'($urandom), CW'($urandom), RW'(9), 2, n);
    wait_drained();                                 // sender pauses mid-circle
    while (circle_active) send_step(n);
  endtask

  task automatic test_random();
    int produced;
    int n;
    int steps;
    int sel;
    logic [RW-1:0] r;
    produced = 0;
    while (produced < RANDOM_PIX * PIX_PER_STEP) begin
      case ($urandom_range(0, 2))
        0: begin
          src_gap_max = 0;
          snk_gap_max = 0;
        end
        1: begin
          src_gap_max = 12;
          snk_gap_max = 12;
        end
        default: begin
          src_gap_max = $urandom_range(0, 12);
          snk_gap_max = $urandom_range(0, 12);
        end
      endcase
      if ($urandom_range(0, 9) == 0) send_step(n);  // noise
      sel = $urandom_range(0, 9);
      if (sel < 7)      r = RW'($urandom_range(0, 12));
      else if (sel < 9) r = RW'($urandom_range(13, 40));
      else              r = RW'($urandom_range(41, (1 << RW) - 1));
      if (r > 40)                          steps = $urandom_range(1, 5);
      else if ($urandom_range(0, 4) == 0)  steps = $urandom_range(0, 3);
      else                                 steps = 1 << 20;
      run_circle(CW'($urandom), CW'($urandom), r, steps, n);
      produced += n;
      if ($urandom_range(0, 5) == 0) send_step(n);
    end
  endtask

  // output side: per-pixel random stall, plus an optional long hold-off
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        stall_left = snk_gap_max > 0 ? $urandom_range(0, snk_gap_max) : 0;
      else if (stall_left > 0)
        stall_left--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel transfer: x %0d y %0d", out_ch.pixel_x, out_ch.pixel_y);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.pixel_x !== want.px) begin
          $error("pixel_x: expected %0d, got %0d", want.px, out_ch.pixel_x);
          errors++;
        end
        if (out_ch.pixel_y !== want.py) begin
          $error("pixel_y: expected %0d, got %0d", want.py, out_ch.pixel_y);
          errors++;
        end
        if (out_ch.last_of_item !== want.last) begin
          $error("last_of_item: expected %0b, got %0b", want.last, out_ch.last_of_item);
          errors++;
        end
        if (out_ch.circle_done !== want.done) begin
          $error("circle_done: expected %0b, got %0b", want.done, out_ch.circle_done);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    errors         = 0;
    cycles         = 0;
    src_gap_max    = 0;
    snk_gap_max    = 0;
    hold_cycles    = 0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_START;
    in_ch.center_x = '0;
    in_ch.center_y = '0;
    in_ch.radius   = '0;
    ctr_col        = '0;
    ctr_row        = '0;
    off_x          = '0;
    off_y          = '0;
    decision       = '0;
    ddx            = '0;
    ddy            = '0;
    circle_active  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (16) @(posedge clk);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
